### sv/pfe_pkg.sv
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared types, codes and the per-entry color step for the palette fade engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfe_pkg;

  localparam int ENTRIES_DEF    = 64;
  localparam int FADE_TICKS_DEF = 22;
  localparam int LEVEL_W        = 3;
  localparam int COLOR_W        = 3 * LEVEL_W;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 6;
  localparam int MODE_W         = 3;
  localparam int BANK_W         = 2;
  localparam int ENTRY_W        = 6;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 3'd7;
  localparam logic [COLOR_W-1:0] COLOR_WHITE = 9'h1ff;
  localparam logic [COLOR_W-1:0] COLOR_BLACK = 9'h000;

  localparam logic [MODE_W-1:0] MODE_NONE      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FADE_IN   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FADE_OUT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FLASH_IN  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FLASH_OUT = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] CFG_FADE_MODE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_ENTRY = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENTRY_SPAN  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_LAYER_B_ON  = 2'd3;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_ARM   = 2'd2,
    REQ_TICK  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    WALK_CLEAR = 2'd0,
    WALK_BLACK = 2'd1,
    WALK_WHITE = 2'd2,
    WALK_TICK  = 2'd3
  } walk_t;

  typedef struct packed {
    logic  capture;
    logic  wr_entry;
    logic  rd_entry;
    logic  count_clear;
    logic  count_step;
    logic  start;
    walk_t kind;
    logic  run;
    logic  load_out;
  } pfe_cmd_t;

  typedef struct packed {
    req_t              req;
    logic [MODE_W-1:0] mode;
    logic              range_ok;
    logic              walk_last;
    logic              out_free;
  } pfe_status_t;

  function automatic logic mode_active(logic [MODE_W-1:0] mode);
    return mode inside {[MODE_FADE_IN:MODE_FLASH_OUT]};
  endfunction

  function automatic logic [COLOR_W-1:0] step_color(logic [MODE_W-1:0] mode,
                                                    logic [COLOR_W-1:0] cur,
                                                    logic [COLOR_W-1:0] tgt);
    logic [LEVEL_W-1:0] r, g, b, tr, tg, tb;
    r  = cur[8:6];
    g  = cur[5:3];
    b  = cur[2:0];
    tr = tgt[8:6];
    tg = tgt[5:3];
    tb = tgt[2:0];
    case (mode)
      MODE_FADE_IN: begin
        if (tb > b) b = b + 3'd1;
        else if (tg > g) g = g + 3'd1;
        else if (tr > r) r = r + 3'd1;
      end
      MODE_FLASH_IN: begin
        if (tb < b) b = b - 3'd1;
        else if (tg < g) g = g - 3'd1;
        else if (tr < r) r = r - 3'd1;
      end
      MODE_FADE_OUT: begin
        if (r != 3'd0) r = r - 3'd1;
        else if (g != 3'd0) g = g - 3'd1;
        else if (b != 3'd0) b = b - 3'd1;
      end
      default: begin
        if (r != LEVEL_MAX) r = r + 3'd1;
        else if (g != LEVEL_MAX) g = g + 3'd1;
        else if (b != LEVEL_MAX) b = b + 3'd1;
      end
    endcase
    return {r, g, b};
  endfunction

endpackage

### sv/pfe_ctrl.sv
// ----------------------------------------------------------------------------
// pfe_ctrl
// Sequencer: takes one request beat, drives the datapath walk, loads the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfe_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pfe_pkg::pfe_status_t st,
  output pfe_pkg::pfe_cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_CLEAR    = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_DISPATCH = 8'b0000_0100,
    S_READ     = 8'b0000_1000,
    S_FILL     = 8'b0001_0000,
    S_STEP     = 8'b0010_0000,
    S_DRAIN    = 8'b0100_0000,
    S_RESULT   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_CLEAR: begin
        cmd.run = 1'b1;
        if (st.walk_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.req)
          pfe_pkg::REQ_WRITE: begin
            cmd.wr_entry = 1'b1;
            state_next   = S_RESULT;
          end
          pfe_pkg::REQ_READ: begin
            cmd.rd_entry = 1'b1;
            state_next   = S_READ;
          end
          pfe_pkg::REQ_ARM: begin
            cmd.count_clear = 1'b1;
            if (st.mode == pfe_pkg::MODE_FADE_IN && st.range_ok) begin
              cmd.start  = 1'b1;
              cmd.kind   = pfe_pkg::WALK_BLACK;
              state_next = S_FILL;
            end else if (st.mode == pfe_pkg::MODE_FLASH_IN) begin
              cmd.start  = 1'b1;
              cmd.kind   = pfe_pkg::WALK_WHITE;
              state_next = S_FILL;
            end else begin
              state_next = S_RESULT;
            end
          end
          pfe_pkg::REQ_TICK: begin
            if (pfe_pkg::mode_active(st.mode)) begin
              cmd.count_step = 1'b1;
              if (st.range_ok) begin
                cmd.start  = 1'b1;
                cmd.kind   = pfe_pkg::WALK_TICK;
                state_next = S_STEP;
              end else begin
                state_next = S_RESULT;
              end
            end else begin
              state_next = S_RESULT;
            end
          end
          default: state_next = S_RESULT;
        endcase
      end
      S_READ: begin
        state_next = S_RESULT;
      end
      S_FILL: begin
        cmd.run = 1'b1;
        if (st.walk_last) state_next = S_RESULT;
      end
      S_STEP: begin
        cmd.run = 1'b1;
        if (st.walk_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### sv/pfe_datapath.sv
// ----------------------------------------------------------------------------
// pfe_datapath
// Palette store, config registers, range walker, tick counter and result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfe_datapath #(
  parameter int ENTRIES    = pfe_pkg::ENTRIES_DEF,
  parameter int FADE_TICKS = pfe_pkg::FADE_TICKS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [pfe_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pfe_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [1:0]                       req_type,
  input  logic [pfe_pkg::BANK_W-1:0]       bank,
  input  logic [pfe_pkg::ENTRY_W-1:0]      entry,
  input  logic [pfe_pkg::LEVEL_W-1:0]      red_in,
  input  logic [pfe_pkg::LEVEL_W-1:0]      green_in,
  input  logic [pfe_pkg::LEVEL_W-1:0]      blue_in,
  input  pfe_pkg::pfe_cmd_t                cmd,
  output pfe_pkg::pfe_status_t             st,
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic                             done_res,
  output logic [pfe_pkg::LEVEL_W-1:0]      red_out,
  output logic [pfe_pkg::LEVEL_W-1:0]      green_out,
  output logic [pfe_pkg::LEVEL_W-1:0]      blue_out
);

  localparam int EW    = $clog2(ENTRIES);
  localparam int AW    = $clog2(4 * ENTRIES);
  localparam int SW    = (EW + 1 > 7) ? EW + 1 : 7;
  localparam int CW    = $clog2(FADE_TICKS + 1);
  localparam int DEPTH = 4 * ENTRIES;
  localparam int CLRW  = pfe_pkg::COLOR_W;

  // config
  logic [pfe_pkg::MODE_W-1:0]  fade_mode;
  logic [pfe_pkg::ENTRY_W-1:0] first_entry;
  logic [pfe_pkg::ENTRY_W-1:0] entry_span;
  logic                        second_layer_on;

  // captured request
  pfe_pkg::req_t               req_q;
  logic [pfe_pkg::BANK_W-1:0]  bank_q;
  logic [pfe_pkg::ENTRY_W-1:0] entry_q;
  logic [CLRW-1:0]             color_q;

  // walker
  pfe_pkg::walk_t walk_kind;
  logic [EW-1:0]  ptr;
  logic [1:0]     sbank;
  logic [EW-1:0]  p_first, p_last, start_ptr;
  logic           row_last, bank_last, layer_b;

  // range
  logic [SW-1:0] range_sum;
  logic [EW-1:0] lo, hi;
  logic          range_ok, entry_ok;

  // memory
  logic [CLRW-1:0] mem [DEPTH];
  logic [CLRW-1:0] rd_a, rd_b, wd;
  logic [AW-1:0]   walk_addr, walk_tgt, req_addr, rd_a_addr, wa, s1_addr;
  logic            we, rd_a_en, rd_b_en, s1_valid;

  // tick count
  logic [CW-1:0] tick_count, count_inc;
  logic          wrap;

  function automatic logic [AW-1:0] mem_addr(logic [1:0] b, logic [EW-1:0] p);
    return AW'(b) * AW'(ENTRIES) + AW'(p);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_mode       <= pfe_pkg::MODE_NONE;
      first_entry     <= '0;
      entry_span      <= 6'd63;
      second_layer_on <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        pfe_pkg::CFG_FADE_MODE:   fade_mode       <= cfg_data[pfe_pkg::MODE_W-1:0];
        pfe_pkg::CFG_FIRST_ENTRY: first_entry     <= cfg_data;
        pfe_pkg::CFG_ENTRY_SPAN:  entry_span      <= cfg_data;
        pfe_pkg::CFG_LAYER_B_ON:  second_layer_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q   <= pfe_pkg::req_t'(req_type);
      bank_q  <= bank;
      entry_q <= entry;
      color_q <= {red_in, green_in, blue_in};
    end
  end

  assign range_sum = SW'(first_entry) + SW'(entry_span);
  assign range_ok  = SW'(first_entry) < SW'(ENTRIES);
  assign entry_ok  = SW'(entry_q) < SW'(ENTRIES);
  assign lo        = EW'(SW'(first_entry));
  assign hi        = EW'((range_sum > SW'(ENTRIES - 1)) ? SW'(ENTRIES - 1) : range_sum);
  assign layer_b   = (fade_mode == pfe_pkg::MODE_FADE_OUT) ||
                     (fade_mode == pfe_pkg::MODE_FLASH_OUT) || second_layer_on;

  // walk bounds
  always_comb begin
    if (walk_kind == pfe_pkg::WALK_CLEAR || walk_kind == pfe_pkg::WALK_WHITE) begin
      p_first = '0;
      p_last  = EW'(ENTRIES - 1);
    end else begin
      p_first = lo;
      p_last  = hi;
    end
    case (walk_kind)
      pfe_pkg::WALK_CLEAR: bank_last = (sbank == 2'd3);
      pfe_pkg::WALK_TICK:  bank_last = (sbank == 2'd2) || !layer_b;
      default:             bank_last = 1'b1;
    endcase
    row_last  = (ptr == p_last);
    start_ptr = (cmd.kind == pfe_pkg::WALK_CLEAR || cmd.kind == pfe_pkg::WALK_WHITE) ?
                '0 : lo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_kind <= pfe_pkg::WALK_CLEAR;
      ptr       <= '0;
      sbank     <= '0;
    end else if (cmd.start) begin
      walk_kind <= cmd.kind;
      ptr       <= start_ptr;
      sbank     <= '0;
    end else if (cmd.run) begin
      if (row_last) begin
        ptr   <= p_first;
        sbank <= (walk_kind == pfe_pkg::WALK_CLEAR) ? sbank + 2'd1 : 2'd2;
      end else begin
        ptr <= ptr + EW'(1);
      end
    end
  end

  assign walk_addr = mem_addr(sbank, ptr);
  assign walk_tgt  = walk_addr + AW'(ENTRIES);
  assign req_addr  = mem_addr(bank_q, EW'(SW'(entry_q)));
  assign rd_a_addr = cmd.rd_entry ? req_addr : walk_addr;
  assign rd_b_en   = cmd.run && (walk_kind == pfe_pkg::WALK_TICK);
  assign rd_a_en   = cmd.rd_entry || rd_b_en;

  // write port: tick write-back, clear or fill sweep, or a single entry write
  always_comb begin
    we = 1'b0;
    wa = s1_addr;
    wd = pfe_pkg::step_color(fade_mode, rd_a, rd_b);
    if (s1_valid) begin
      we = 1'b1;
    end else if (cmd.run && walk_kind != pfe_pkg::WALK_TICK) begin
      we = 1'b1;
      wa = walk_addr;
      wd = (walk_kind == pfe_pkg::WALK_WHITE) ? pfe_pkg::COLOR_WHITE : pfe_pkg::COLOR_BLACK;
    end else if (cmd.wr_entry && entry_ok) begin
      we = 1'b1;
      wa = req_addr;
      wd = color_q;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (rd_a_en) rd_a <= mem[rd_a_addr];
    if (rd_b_en) rd_b <= mem[walk_tgt];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= rd_b_en;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr <= walk_addr;
  end

  assign count_inc = tick_count + CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      wrap       <= 1'b0;
    end else if (cmd.count_clear) begin
      tick_count <= '0;
    end else if (cmd.count_step) begin
      if (count_inc >= CW'(FADE_TICKS)) begin
        tick_count <= '0;
        wrap       <= 1'b1;
      end else begin
        tick_count <= count_inc;
        wrap       <= 1'b0;
      end
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      done_res <= (req_q == pfe_pkg::REQ_TICK) &&
                  (!pfe_pkg::mode_active(fade_mode) || wrap);
      if (req_q == pfe_pkg::REQ_READ && entry_ok) begin
        {red_out, green_out, blue_out} <= rd_a;
      end else begin
        {red_out, green_out, blue_out} <= '0;
      end
    end
  end

  assign st.req       = req_q;
  assign st.mode      = fade_mode;
  assign st.range_ok  = range_ok;
  assign st.walk_last = row_last && bank_last;
  assign st.out_free  = !out_valid || !out_stall;

`ifndef SYNTHESIS
  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("result loaded over a pending beat");

  a_wb_current_bank: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> ((s1_addr < AW'(ENTRIES)) ||
                  ((s1_addr >= AW'(2 * ENTRIES)) && (s1_addr < AW'(3 * ENTRIES)))))
    else $error("tick write-back hit a target bank");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    tick_count < CW'(FADE_TICKS))
    else $error("tick count out of range");

  a_wrap_count: assert property (@(posedge clk) disable iff (rst)
    wrap |-> (tick_count == '0))
    else $error("done flag set with nonzero count");
`endif

endmodule

### sv/palette_fade_engine.sv
// ----------------------------------------------------------------------------
// palette_fade_engine
// Two-layer palette store with frame-tick driven fades toward target banks.
//
// Request channel (in_valid/in_stall) carries req_type, bank, entry and the
// rgb levels; every request beat yields exactly one result beat on the
// out_valid/out_stall channel (done_res and the rgb levels of a read).
// Config is a plain write port (cfg_write, cfg_index, cfg_data); the user
// must write it only while no request is in flight, which the block does
// not enforce. A write or an arm without fill goes from dispatch straight
// to the result; a read passes a read state first. An arm that fills layer
// A sweeps it first; a tick in an active fade walks the range of each
// enabled layer. The walk is bound by the single write port of the store,
// which retires one entry per cycle. One request is in flight at a time.
// Reset clears the whole store with a sweep, and in_stall stays high
// until the sweep ends.
// A stalled result waits in the output register; the next request may be
// taken meanwhile, and its result waits until the register frees up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module palette_fade_engine #(
  parameter int ENTRIES    = pfe_pkg::ENTRIES_DEF,
  parameter int FADE_TICKS = pfe_pkg::FADE_TICKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [pfe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pfe_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      req_type,
  input  logic [pfe_pkg::BANK_W-1:0]      bank,
  input  logic [pfe_pkg::ENTRY_W-1:0]     entry,
  input  logic [pfe_pkg::LEVEL_W-1:0]     red_in,
  input  logic [pfe_pkg::LEVEL_W-1:0]     green_in,
  input  logic [pfe_pkg::LEVEL_W-1:0]     blue_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            done_res,
  output logic [pfe_pkg::LEVEL_W-1:0]     red_out,
  output logic [pfe_pkg::LEVEL_W-1:0]     green_out,
  output logic [pfe_pkg::LEVEL_W-1:0]     blue_out
);

  pfe_pkg::pfe_cmd_t    cmd;
  pfe_pkg::pfe_status_t st;

  pfe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  pfe_datapath #(
    .ENTRIES    (ENTRIES),
    .FADE_TICKS (FADE_TICKS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_type  (req_type),
    .bank      (bank),
    .entry     (entry),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .cmd       (cmd),
    .st        (st),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .done_res  (done_res),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out)
  );

endmodule
